// ===== rtl/core/bcc3_pkg.sv =====
// Shared types and constants for the 3x3 basis coordinate solver.
package bcc3_pkg;

   // Width of every coordinate and vector component, with 16 fraction bits.
   localparam int ValueBits = 32;
   localparam int ThrBits = 40;
   localparam logic [ThrBits-1:0] ThrReset = 40'd281474977;
   localparam int FracBits = 16;

   typedef struct packed {
      logic signed [ValueBits-1:0] basis1_x;
      logic signed [ValueBits-1:0] basis1_y;
      logic signed [ValueBits-1:0] basis1_z;
      logic signed [ValueBits-1:0] basis2_x;
      logic signed [ValueBits-1:0] basis2_y;
      logic signed [ValueBits-1:0] basis2_z;
      logic signed [ValueBits-1:0] basis3_x;
      logic signed [ValueBits-1:0] basis3_y;
      logic signed [ValueBits-1:0] basis3_z;
      logic signed [ValueBits-1:0] target_x;
      logic signed [ValueBits-1:0] target_y;
      logic signed [ValueBits-1:0] target_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [ValueBits-1:0] coord_first;
      logic signed [ValueBits-1:0] coord_second;
      logic signed [ValueBits-1:0] coord_third;
      logic                        degenerate;
      logic                        saturated;
   } rsp_payload_type;

endpackage

// ===== rtl/core/bcc3_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage from a seeded remainder.
module bcc3_divider import bcc3_pkg::*; #(
   parameter int NumBits = 36,
   parameter int DenBits = 98,
   parameter int TagBits = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [DenBits-1:0]   in_den,
   input  logic [3*DenBits-1:0] in_rem,
   input  logic [3*NumBits-1:0] in_num,
   input  logic [TagBits-1:0]   in_tag,
   output logic                 out_valid,
   output logic [3*NumBits-1:0] out_quo,
   output logic [TagBits-1:0]   out_tag
);
   // Each lane carries a remainder and a shift register holding numerator bits,
   // which turn into quotient bits from the bottom. A lane's seed remainder must
   // be below the divisor, so that the quotient fits in NumBits.
   logic [NumBits:0]           valid_ff;
   logic [DenBits-1:0]         den_ff [NumBits+1];
   logic [DenBits-1:0]         rem_ff [NumBits+1][3];
   logic [NumBits-1:0]         nq_ff  [NumBits+1][3];
   logic [TagBits-1:0]         tag_ff [NumBits+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NumBits-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff[0] <= in_den;
         tag_ff[0] <= in_tag;
         for (int l = 0; l < 3; l++) begin
            rem_ff[0][l] <= in_rem[l*DenBits +: DenBits];
            nq_ff[0][l]  <= in_num[l*NumBits +: NumBits];
         end
      end
   end

   for (genvar s = 0; s < NumBits; s++) begin : g_stage
      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [DenBits:0] trial_in;
         logic [DenBits:0] diff_in;
         assign trial_in = {rem_ff[s][l], nq_ff[s][l][NumBits-1]};
         assign diff_in  = trial_in - {1'b0, den_ff[s]};
         always_ff @(posedge clock) begin
            if (advance) begin
               if (!diff_in[DenBits]) begin
                  rem_ff[s+1][l] <= diff_in[DenBits-1:0];
               end else begin
                  rem_ff[s+1][l] <= trial_in[DenBits-1:0];
               end
               nq_ff[s+1][l] <= {nq_ff[s][l][NumBits-2:0], ~diff_in[DenBits]};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[s+1] <= den_ff[s];
            tag_ff[s+1] <= tag_ff[s];
         end
      end
   end

   assign out_valid = valid_ff[NumBits];
   assign out_tag   = tag_ff[NumBits];
   for (genvar l = 0; l < 3; l++) begin : g_out
      assign out_quo[l*NumBits +: NumBits] = nq_ff[NumBits][l];
   end
endmodule

// ===== rtl/core/basis_coordinates_cramer_3x3_core.sv =====
// Top level of the pipelined 3x3 Cramer's rule basis coordinate solver.
// From an input transfer to its result the pipeline has nine operand stages,
// ValueBits + 3 divider stages and the output register.
// Throughput: one item per cycle; the whole pipeline holds only while a finished
// result is stalled, so every stage is a register and nothing is lost or repeated.
// Reset clears every valid bit and loads the threshold with its default of about 1e-6.
module basis_coordinates_cramer_3x3_core import bcc3_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [ThrBits-1:0] csr_data
);
   // Widths: products of two values, cross terms, triple products at 3*VB+3.
   // A cross term is split at VB bits so that every multiplier stays near VB by VB.
   localparam int VB  = ValueBits;
   localparam int PW  = 2 * VB;
   localparam int CW  = PW + 1;
   localparam int SW  = 2 * VB + 1;
   localparam int TW  = 3 * VB + 3;
   localparam int DW  = TW + FracBits + 2;
   localparam int QB  = VB + 2;
   localparam int DepthPre = 9;
   // Tag through the divider: sign per lane, the degenerate flag, overflow per lane.
   localparam int TagBits = 7;
   localparam int TagDegen = 3;
   localparam int TagBig = 4;

   logic advance;
   logic [ThrBits-1:0] thr_ff;

   // One global enable: the pipe moves unless a finished result sits stalled.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ThrReset;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // Stage 1: capture the operands.
   logic [DepthPre-1:0] v_ff;
   logic signed [VB-1:0] e_ff [3][3];
   logic signed [VB-1:0] w1_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[DepthPre-2:0], req_valid};
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         e_ff[0][0] <= req_payload.basis1_x;
         e_ff[0][1] <= req_payload.basis1_y;
         e_ff[0][2] <= req_payload.basis1_z;
         e_ff[1][0] <= req_payload.basis2_x;
         e_ff[1][1] <= req_payload.basis2_y;
         e_ff[1][2] <= req_payload.basis2_z;
         e_ff[2][0] <= req_payload.basis3_x;
         e_ff[2][1] <= req_payload.basis3_y;
         e_ff[2][2] <= req_payload.basis3_z;
         w1_ff[0] <= req_payload.target_x;
         w1_ff[1] <= req_payload.target_y;
         w1_ff[2] <= req_payload.target_z;
      end
   end

   // Stage 2: the eighteen cross-product multiplies.
   // Stage 3: cross products by subtraction.
   logic signed [PW-1:0] pa_ff [3][3], pb_ff [3][3];
   logic signed [CW-1:0] cr_ff [3][3];
   logic signed [VB-1:0] e2_ff [3], w2_ff [3], w3_ff [3], e3_ff [3];
   for (genvar k = 0; k < 3; k++) begin : g_cross
      for (genvar j = 0; j < 3; j++) begin : g_comp
         localparam int A  = (j + 1) % 3;
         localparam int B  = (j + 2) % 3;
         localparam int U  = (k + 1) % 3;
         localparam int V2 = (k + 2) % 3;
         always_ff @(posedge clock) begin
            if (advance) begin
               pa_ff[k][j] <= PW'(e_ff[U][A] * e_ff[V2][B]);
               pb_ff[k][j] <= PW'(e_ff[U][B] * e_ff[V2][A]);
               cr_ff[k][j] <= CW'(pa_ff[k][j]) - CW'(pb_ff[k][j]);
            end
         end
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         e2_ff <= e_ff[0];
         w2_ff <= w1_ff;
         e3_ff <= e2_ff;
         w3_ff <= w2_ff;
      end
   end

   // Stage 4: partial products of the triple products. Each cross term is cut
   // into a signed high slice and an unsigned low slice of VB bits.
   logic signed [SW-1:0] nhi_ff [3][3], nlo_ff [3][3];
   logic signed [SW-1:0] dhi_ff [3], dlo_ff [3];
   for (genvar k = 0; k < 3; k++) begin : g_dot
      for (genvar j = 0; j < 3; j++) begin : g_term
         always_ff @(posedge clock) begin
            if (advance) begin
               nhi_ff[k][j] <= SW'($signed(cr_ff[k][j][CW-1:VB]) * w3_ff[j]);
               nlo_ff[k][j] <= SW'($signed({1'b0, cr_ff[k][j][VB-1:0]}) * w3_ff[j]);
            end
         end
      end
   end
   // The determinant uses e1 with the cross product of e2 and e3.
   for (genvar j = 0; j < 3; j++) begin : g_det
      always_ff @(posedge clock) begin
         if (advance) begin
            dhi_ff[j] <= SW'($signed(cr_ff[0][j][CW-1:VB]) * e3_ff[j]);
            dlo_ff[j] <= SW'($signed({1'b0, cr_ff[0][j][VB-1:0]}) * e3_ff[j]);
         end
      end
   end

   // Stage 5: the partial products are joined into full triple-product terms.
   logic signed [CW+VB-1:0] dp_ff [3];
   logic signed [CW+VB-1:0] np_ff [3][3];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < 3; j++) begin
            dp_ff[j] <= ((CW+VB)'(dhi_ff[j]) <<< VB) + (CW+VB)'(dlo_ff[j]);
            for (int k = 0; k < 3; k++) begin
               np_ff[k][j] <= ((CW+VB)'(nhi_ff[k][j]) <<< VB) + (CW+VB)'(nlo_ff[k][j]);
            end
         end
      end
   end

   // Stage 6: sums.
   logic signed [TW-1:0] det_ff, num_ff [3];
   always_ff @(posedge clock) begin
      if (advance) begin
         det_ff <= TW'(dp_ff[0]) + TW'(dp_ff[1]) + TW'(dp_ff[2]);
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= TW'(np_ff[k][0]) + TW'(np_ff[k][1]) + TW'(np_ff[k][2]);
         end
      end
   end

   // Stage 7: magnitudes, signs, degenerate test.
   logic [TW-1:0] adet_ff, anum_ff [3];
   logic [2:0]    neg7_ff;
   logic          degen7_ff;
   logic [TW-1:0] adet_in;
   assign adet_in = det_ff[TW-1] ? TW'(-det_ff) : TW'(det_ff);
   always_ff @(posedge clock) begin
      if (advance) begin
         adet_ff   <= adet_in;
         degen7_ff <= (adet_in == '0) || (adet_in < TW'(thr_ff));
         for (int k = 0; k < 3; k++) begin
            anum_ff[k] <= num_ff[k][TW-1] ? TW'(-num_ff[k]) : TW'(num_ff[k]);
            neg7_ff[k] <= num_ff[k][TW-1] ^ det_ff[TW-1];
         end
      end
   end

   // Stage 8: rounding to nearest is folded into the division as
   // (2^17*|n| + |d|) / (2|d|), which keeps 16 fraction bits.
   logic [DW-1:0] rn_ff [3];
   logic [DW-1:0] dd_ff;
   logic [2:0]    neg8_ff;
   logic          degen8_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         dd_ff     <= DW'(adet_ff) << 1;
         degen8_ff <= degen7_ff;
         neg8_ff   <= neg7_ff;
         for (int k = 0; k < 3; k++) begin
            rn_ff[k] <= (DW'(anum_ff[k]) << (FracBits + 1)) + DW'(adet_ff);
         end
      end
   end

   // Stage 9: the bits of rn above the low QB bits seed the divider remainder.
   // That seed is below the divisor exactly when the quotient fits QB bits;
   // otherwise the quotient is far out of range and the lane saturates.
   logic [DW-1:0]      seed_in [3];
   logic [2:0]         big_in;
   logic [3*DW-1:0]    seed_ff;
   logic [3*QB-1:0]    low_ff;
   logic [TagBits-1:0] tag_ff;
   logic [DW-1:0]      dd9_ff;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         seed_in[k] = rn_ff[k] >> QB;
         big_in[k]  = seed_in[k] >= dd_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         dd9_ff <= dd_ff;
         tag_ff <= {big_in, degen8_ff, neg8_ff};
         for (int k = 0; k < 3; k++) begin
            seed_ff[k*DW +: DW] <= big_in[k] ? '0 : seed_in[k];
            low_ff[k*QB +: QB]  <= big_in[k] ? '1 : rn_ff[k][QB-1:0];
         end
      end
   end

   // Divider: QB + 1 stages, one quotient bit per stage in each of the three lanes.
   logic               div_valid;
   logic [3*QB-1:0]    div_quo;
   logic [TagBits-1:0] div_tag;
   bcc3_divider #(
      .NumBits(QB),
      .DenBits(DW),
      .TagBits(TagBits)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .in_valid(v_ff[DepthPre-1]),
      .in_den(dd9_ff),
      .in_rem(seed_ff),
      .in_num(low_ff),
      .in_tag(tag_ff),
      .out_valid(div_valid),
      .out_quo(div_quo),
      .out_tag(div_tag)
   );

   // Final stage: clamp, sign, degenerate override.
   localparam logic [QB-1:0] PosLim = QB'((64'd1 << (VB - 1)) - 64'd1);
   localparam logic [QB-1:0] NegLim = QB'(64'd1 << (VB - 1));
   rsp_payload_type out_ff;
   logic            out_valid_ff;
   logic [VB-1:0]   coord_in [3];
   logic [QB-1:0]   lim_in [3];
   logic [QB-1:0]   mag_in [3];
   logic [2:0]      sat_in;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lim_in[k]   = div_tag[k] ? NegLim : PosLim;
         sat_in[k]   = div_tag[TagBig+k] || (div_quo[k*QB +: QB] > lim_in[k]);
         mag_in[k]   = sat_in[k] ? lim_in[k] : div_quo[k*QB +: QB];
         coord_in[k] = div_tag[k] ? VB'(-mag_in[k]) : VB'(mag_in[k]);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= div_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff.degenerate   <= div_tag[TagDegen];
         out_ff.saturated    <= !div_tag[TagDegen] && (|sat_in);
         out_ff.coord_first  <= div_tag[TagDegen] ? '0 : coord_in[0];
         out_ff.coord_second <= div_tag[TagDegen] ? '0 : coord_in[1];
         out_ff.coord_third  <= div_tag[TagDegen] ? '0 : coord_in[2];
      end
   end
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

`ifndef ASSERT_OFF
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.degenerate |-> rsp_payload.coord_first == '0 &&
      rsp_payload.coord_second == '0 && rsp_payload.coord_third == '0 &&
      !rsp_payload.saturated)
      else $error("degenerate result not cleared");
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output stall");
`endif
endmodule
